// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the inversion pair counter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define IPC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define IPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IPC_ASSERT(lbl, clk, rst, prop, msg)
`define IPC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define IPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/ipc_pkg.sv =====
// Types and constants of the inversion pair counter
package ipc_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 19;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic valid;
      logic last;
      logic drop;
   } ipc_ctrl_type;

endpackage

// ===== hw/rtl/ipc_channels.sv =====
// Valid/ready channel interfaces for request and response words
interface ipc_req_if;
   import ipc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      last_item;

   modport source (output valid, output value, output last_item, input ready);
   modport sink (input valid, input value, input last_item, output ready);
endinterface

interface ipc_rsp_if;
   import ipc_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] pair_count;
   logic               overflow;

   modport source (output valid, output pair_count, output overflow, input ready);
   modport sink (input valid, input pair_count, input overflow, output ready);
endinterface

// ===== hw/rtl/ipc_cell.sv =====
// One compare cell: holds a stored value and counts passing words below it
module ipc_cell #(
   parameter int IDX_W      = 11,
   parameter int CELL_INDEX = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic signed [ipc_pkg::VALUE_W-1:0] in_key,
   input  logic [IDX_W-1:0]                   in_idx,
   input  logic [IDX_W-1:0]                   in_count,
   input  ipc_pkg::ipc_ctrl_type              in_ctrl,
   output logic signed [ipc_pkg::VALUE_W-1:0] out_key,
   output logic [IDX_W-1:0]                   out_idx,
   output logic [IDX_W-1:0]                   out_count,
   output ipc_pkg::ipc_ctrl_type              out_ctrl
);
   import ipc_pkg::*;

   localparam logic [IDX_W-1:0] CellPos = IDX_W'(CELL_INDEX);

   logic signed [VALUE_W-1:0] stored_ff;
   logic signed [VALUE_W-1:0] key_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic [IDX_W-1:0]          count_ff;
   logic [IDX_W-1:0]          count_in;
   ipc_ctrl_type              ctrl_ff;
   logic                      live;
   logic                      hit;
   logic                      store;

   assign live     = in_ctrl.valid && !in_ctrl.drop;
   assign hit      = live && (CellPos < in_idx) && (stored_ff > in_key);
   assign store    = en && live && (in_idx == CellPos);
   assign count_in = in_count + IDX_W'(hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= in_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         key_ff   <= in_key;
         idx_ff   <= in_idx;
         count_ff <= count_in;
      end
      if (store) begin
         stored_ff <= in_key;
      end
   end

   assign out_key   = key_ff;
   assign out_idx   = idx_ff;
   assign out_count = count_ff;
   assign out_ctrl  = ctrl_ff;
endmodule

// ===== hw/rtl/ipc_chain.sv =====
// Row of compare cells, one per stored value, passing words left to right
module ipc_chain #(
   parameter int IDX_W = 11,
   parameter int DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic signed [ipc_pkg::VALUE_W-1:0] in_key,
   input  logic [IDX_W-1:0]                   in_idx,
   input  ipc_pkg::ipc_ctrl_type              in_ctrl,
   output logic [IDX_W-1:0]                   out_count,
   output ipc_pkg::ipc_ctrl_type              out_ctrl
);
   import ipc_pkg::*;

   logic signed [VALUE_W-1:0] key_w   [DEPTH+1];
   logic [IDX_W-1:0]          idx_w   [DEPTH+1];
   logic [IDX_W-1:0]          count_w [DEPTH+1];
   ipc_ctrl_type              ctrl_w  [DEPTH+1];

   assign key_w[0]   = in_key;
   assign idx_w[0]   = in_idx;
   assign count_w[0] = '0;
   assign ctrl_w[0]  = in_ctrl;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ipc_cell #(
         .IDX_W      (IDX_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_key    (key_w[i]),
         .in_idx    (idx_w[i]),
         .in_count  (count_w[i]),
         .in_ctrl   (ctrl_w[i]),
         .out_key   (key_w[i+1]),
         .out_idx   (idx_w[i+1]),
         .out_count (count_w[i+1]),
         .out_ctrl  (ctrl_w[i+1])
      );
   end

   assign out_count = count_w[DEPTH];
   assign out_ctrl  = ctrl_w[DEPTH];
endmodule

// ===== hw/rtl/inversion_pair_counter.sv =====
// Inversion pair counter: top level with entry stage, cell row and accumulator
// The last word reaches the result via the entry stage, cell row and response register.
// Throughput: one word per cycle unless halted, set by a row of MAX_ITEMS compare cells.
// The row halts only while a result waits and the next last word reaches its end.
// Reset clears counts, flags and pipeline valids at once; stored values need no clearing.
module inversion_pair_counter #(
   parameter int MAX_ITEMS = 1024
) (
   input logic        clock,
   input logic        reset,
   ipc_req_if.sink    req_if,
   ipc_rsp_if.source  rsp_if
);
   import ipc_pkg::*;

   localparam int IDX_W = $clog2(MAX_ITEMS + 1);
   localparam int SUM_W = ((COUNT_W > IDX_W) ? COUNT_W : IDX_W) + 1;
   localparam logic [IDX_W-1:0] MaxIdx = IDX_W'(MAX_ITEMS);

   logic                      en;
   logic                      accept;
   logic                      full;
   logic [IDX_W-1:0]          fill_ff;
   logic [IDX_W-1:0]          fill_in;
   ipc_ctrl_type              entry_ctrl_ff;
   logic signed [VALUE_W-1:0] entry_key_ff;
   logic [IDX_W-1:0]          entry_idx_ff;
   logic [IDX_W-1:0]          end_count;
   ipc_ctrl_type              end_ctrl;
   logic [COUNT_W-1:0]        total_ff;
   logic [COUNT_W-1:0]        total_in;
   logic [COUNT_W-1:0]        total_sum;
   logic [SUM_W-1:0]          sum;
   logic                      ovf_ff;
   logic                      ovf_in;
   logic                      ovf_next;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_ovf_ff;
   logic                      emit;

   assign en     = !(end_ctrl.valid && end_ctrl.last && rsp_valid_ff && !rsp_if.ready);
   assign accept = req_if.valid && en;
   assign full   = (fill_ff == MaxIdx);

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         if (req_if.last_item) begin
            fill_in = '0;
         end else if (!full) begin
            fill_in = fill_ff + IDX_W'(1);
         end
      end
   end

   ipc_chain #(
      .IDX_W (IDX_W),
      .DEPTH (MAX_ITEMS)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_key    (entry_key_ff),
      .in_idx    (entry_idx_ff),
      .in_ctrl   (entry_ctrl_ff),
      .out_count (end_count),
      .out_ctrl  (end_ctrl)
   );

   // saturate the running total at the widest count a result can carry
   assign sum       = SUM_W'(total_ff) + SUM_W'(end_count);
   assign total_sum = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
   assign emit      = en && end_ctrl.valid && end_ctrl.last;

   always_comb begin
      total_in     = total_ff;
      ovf_next     = ovf_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (en && end_ctrl.valid) begin
         if (end_ctrl.drop) begin
            ovf_next = 1'b1;
         end else begin
            total_in = total_sum;
         end
         ovf_in = ovf_next;
         if (end_ctrl.last) begin
            rsp_valid_in = 1'b1;
            total_in     = '0;
            ovf_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         entry_ctrl_ff <= '0;
         total_ff      <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         if (en) begin
            entry_ctrl_ff <= '{valid: accept, last: req_if.last_item, drop: full};
         end
         total_ff      <= total_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         entry_key_ff <= req_if.value;
         entry_idx_ff <= fill_ff;
      end
      if (emit) begin
         rsp_count_ff <= (end_ctrl.drop) ? total_ff : total_sum;
         rsp_ovf_ff   <= ovf_next;
      end
   end

   assign req_if.ready      = en;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pair_count = rsp_count_ff;
   assign rsp_if.overflow   = rsp_ovf_ff;

`include "assert_macros.svh"

   `IPC_ASSERT(a_fill_bound, clock, reset, fill_ff <= MaxIdx, "fill count beyond store depth")
   `IPC_ASSERT_IMPLY(a_stall_cause, clock, reset, !req_if.ready,
      rsp_if.valid && !rsp_if.ready, "halt without waiting result")
   `IPC_ASSERT_IMPLY(a_drop_full, clock, reset, entry_ctrl_ff.valid && entry_ctrl_ff.drop,
      entry_idx_ff == MaxIdx, "word dropped while store not full")
   `IPC_ASSERT_NEXT(a_seq_clear, clock, reset, emit,
      total_ff == '0 && !ovf_ff && rsp_if.valid, "sequence state not cleared after result")
endmodule

// ===== tb/tb_inversion_pair_counter.sv =====
// Self-checking testbench of the inversion pair counter: streams sequences, checks each total
module tb_inversion_pair_counter;
   timeunit 1ns;
   timeprecision 1ps;

   import ipc_pkg::*;

   localparam int CAPACITY       = 1024;
   localparam int PHASE_WORDS    = 100;
   localparam int TIMEOUT_CYCLES = 400000;

   typedef enum int {
      SPREAD_FULL,
      SPREAD_NARROW,
      SPREAD_EDGES,
      SPREAD_FALLING
   } value_spread_type;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      last_item;
   } seq_word_type;

   typedef struct packed {
      logic [COUNT_W-1:0] pair_count;
      logic               overflow;
   } seq_total_type;

   logic clock;
   logic reset;

   ipc_req_if req_bus ();
   ipc_rsp_if rsp_bus ();

   inversion_pair_counter #(
      .MAX_ITEMS (CAPACITY)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   seq_word_type  pending_words [$];
   seq_total_type awaited_totals [$];

   int words_planned;
   int words_accepted;
   int error_count;
   int send_idle_pct;
   int stall_pct;
   logic word_taken;

   logic signed [VALUE_W-1:0] held_values [CAPACITY];
   int                        held_count;
   int                        tally;
   logic                      dropped;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Count earlier values > v, store the word if not full, close the sequence on its last word
   function void tally_inversions(logic signed [VALUE_W-1:0] v, logic last_item);
      int greater;
      seq_total_type t;
      if (held_count < CAPACITY) begin
         greater = 0;
         for (int k = 0; k < held_count; k++) begin
            if (held_values[k] > v) greater++;
         end
         if (greater > int'(COUNT_MAX) - tally) tally = int'(COUNT_MAX);
         else tally += greater;
         held_values[held_count] = v;
         held_count++;
      end else begin
         dropped = 1'b1;
      end
      if (last_item) begin
         t.pair_count = tally[COUNT_W-1:0];
         t.overflow   = dropped;
         awaited_totals.insert(awaited_totals.size(), t);
         held_count = 0;
         tally      = 0;
         dropped    = 1'b0;
      end
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value(value_spread_type spread, int idx);
      case (spread)
         SPREAD_NARROW: begin
            return int'($urandom_range(15)) - 8;
         end
         SPREAD_EDGES: begin
            case ($urandom_range(4))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return 32'sd0;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         SPREAD_FALLING: begin
            return 32'sd1000000 - idx;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   task automatic push_word(logic signed [VALUE_W-1:0] v, logic last_item);
      seq_word_type w;
      w.value     = v;
      w.last_item = last_item;
      pending_words.insert(pending_words.size(), w);
      words_planned++;
   endtask

   task automatic queue_sequence(int len, value_spread_type spread);
      for (int i = 0; i < len; i++) push_word(pick_value(spread, i), i == len - 1);
   endtask

   task automatic queue_random_part(int budget);
      int queued;
      int len;
      queued = 0;
      while (queued < budget) begin
         if ($urandom_range(9) == 0) len = $urandom_range(200, 25);
         else len = $urandom_range(24, 1);
         queue_sequence(len, value_spread_type'($urandom_range(3)));
         queued += len;
      end
   endtask

   always @(negedge clock) begin
      seq_word_type w;
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!req_bus.valid || word_taken) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               w = pending_words.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.value     <= w.value;
               req_bus.last_item <= w.last_item;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      seq_total_type t;
      if (reset) begin
         word_taken <= 1'b0;
      end else begin
         word_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            tally_inversions(req_bus.value, req_bus.last_item);
            words_accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_totals.size() == 0) begin
               report_mismatch("unexpected word, pair_count", 32'(rsp_bus.pair_count), 32'd0);
            end else begin
               t = awaited_totals.pop_front();
               if (rsp_bus.pair_count !== t.pair_count)
                  report_mismatch("pair_count", 32'(rsp_bus.pair_count), 32'(t.pair_count));
               if (rsp_bus.overflow !== t.overflow)
                  report_mismatch("overflow", 32'(rsp_bus.overflow), 32'(t.overflow));
            end
         end
      end
   end

   initial begin
      reset             = 1'b1;
      words_planned     = 0;
      words_accepted    = 0;
      error_count       = 0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      held_count        = 0;
      tally             = 0;
      dropped           = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single words at both extremes, sign order, equal values, full reversal, mixed extremes
      push_word(32'sh8000_0000, 1'b1);
      push_word(32'sh7FFF_FFFF, 1'b1);
      push_word(32'sh7FFF_FFFF, 1'b0);
      push_word(32'sh8000_0000, 1'b1);
      push_word(32'sh8000_0000, 1'b0);
      push_word(32'sh7FFF_FFFF, 1'b1);
      push_word(32'sd7, 1'b0);
      push_word(32'sd7, 1'b0);
      push_word(32'sd7, 1'b1);
      push_word(32'sd0, 1'b0);
      push_word(-32'sd1, 1'b1);
      push_word(-32'sd1, 1'b0);
      push_word(32'sd0, 1'b1);
      push_word(32'sd3, 1'b0);
      push_word(32'sd2, 1'b0);
      push_word(32'sd1, 1'b0);
      push_word(32'sd0, 1'b1);
      push_word(32'sd1, 1'b0);
      push_word(32'sh8000_0000, 1'b0);
      push_word(32'sh7FFF_FFFF, 1'b0);
      push_word(-32'sd5, 1'b0);
      push_word(32'sd1, 1'b1);
      queue_random_part(PHASE_WORDS);
      wait (words_accepted == words_planned);

      send_idle_pct = 49;
      stall_pct     = 0;
      queue_random_part(PHASE_WORDS);
      wait (words_accepted == words_planned);

      send_idle_pct = 0;
      stall_pct     = 49;
      queue_random_part(PHASE_WORDS);
      wait (words_accepted == words_planned);

      // fill the store with a full reversal, then drop the excess and the last word
      send_idle_pct = 35;
      stall_pct     = 35;
      queue_random_part(PHASE_WORDS / 2);
      queue_sequence(CAPACITY + 4, SPREAD_FALLING);
      queue_random_part(PHASE_WORDS / 2);
      wait (words_accepted == words_planned);

      wait (awaited_totals.size() == 0);
      repeat (CAPACITY + 8) @(posedge clock);

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ipc_pkg.sv
hw/rtl/ipc_channels.sv
hw/rtl/ipc_cell.sv
hw/rtl/ipc_chain.sv
hw/rtl/inversion_pair_counter.sv
tb/tb_inversion_pair_counter.sv
